// ===== rtl/fpr_pkg.sv =====
package fpr_pkg;

  localparam int FRAMES = 16;
  localparam int COUNT_BITS = 16;
  localparam int PAGE_W = 16;
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NUM_W = $clog2(FRAMES + 1);
  localparam int ENTRY_W = PAGE_W + COUNT_BITS;
  localparam int CFG_W = 5;
  localparam int SLOT_W = 4;

  localparam logic REG_FRAMES_IN_USE = 1'b0;
  localparam logic REG_EVICT_MODE = 1'b1;

  localparam logic MODE_MFU = 1'b0;
  localparam logic MODE_LFU = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    page_t  page;
    count_t count;
  } entry_t;

endpackage

// ===== rtl/fpr_ram.sv =====
module fpr_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/frequency_page_replacement_top.sv =====
// channel  dir  handshake            beat payload
// in       in   in_valid/in_ready    page_number
// out      out  out_valid/out_ready  hit, slot, evicted, evicted_page
// cfg      in   cfg_write            cfg_index, cfg_data
//
// a reference is worked on in steps: a frame table scan with one read per cycle through the
// registered RAM read port, the close of the scan, then one write-back in ST_WRITE
// the next reference is taken only after the block has gone back to ST_IDLE
// rst clears valid marks, handshake state and the registers to 16 frames, mode 0
// the result sits in an output register; write-back waits while the previous one is not taken
// in_ready is high only when no reference is being worked on
module frequency_page_replacement_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             page_number,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic [3:0]              slot,
  output logic                    evicted,
  output logic [15:0]             evicted_page,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [fpr_pkg::CFG_W-1:0] cfg_data
);

  import fpr_pkg::*;

  logic [CFG_W-1:0] frames_in_use;
  logic             evict_mode;
  logic [FRAMES-1:0] valid;

  state_t state, state_next;

  page_t            page;
  logic [NUM_W-1:0] act;
  logic [NUM_W-1:0] act_now;
  logic [NUM_W-1:0] iss;
  logic             rd_vld;
  idx_t             cmp_idx;

  logic             found;
  idx_t             hit_idx;
  count_t           hit_cnt;
  idx_t             vic_idx;
  count_t           vic_cnt;
  page_t            vic_page;

  logic             ram_we;
  idx_t             ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_q;
  logic [ENTRY_W-1:0] ram_rdata;

  logic             free_found;
  idx_t             free_idx;
  logic             issue;
  logic             better;
  logic             finish;
  idx_t             wr_idx;

  assign ram_q = entry_t'(ram_rdata);

  fpr_ram #(
    .DEPTH (FRAMES),
    .WIDTH (ENTRY_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(iss[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  // active frame count, clamped
  always_comb begin
    if (frames_in_use == '0) begin
      act_now = NUM_W'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      act_now = NUM_W'(FRAMES);
    end else begin
      act_now = NUM_W'(frames_in_use);
    end
  end

  // lowest free active frame
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!valid[i] && (i < int'(act))) begin
        free_found = 1'b1;
        free_idx = idx_t'(i);
      end
    end
  end

  always_comb begin
    if (evict_mode == MODE_MFU) begin
      better = ram_q.count > vic_cnt;
    end else begin
      better = ram_q.count < vic_cnt;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    issue = 1'b0;
    finish = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue = iss < act;
        if (!issue && !rd_vld) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid || out_ready) begin
          finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (found) begin
      wr_idx = hit_idx;
    end else if (free_found) begin
      wr_idx = free_idx;
    end else begin
      wr_idx = vic_idx;
    end
    ram_we = finish;
    ram_waddr = wr_idx;
    ram_wdata.page = page;
    if (found) begin
      ram_wdata.count = (hit_cnt == '1) ? hit_cnt : hit_cnt + count_t'(1);
    end else begin
      ram_wdata.count = count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      frames_in_use <= CFG_W'(16);
      evict_mode <= MODE_MFU;
      valid <= '0;
      out_valid <= 1'b0;
      rd_vld <= 1'b0;
      iss <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAMES_IN_USE: frames_in_use <= cfg_data;
          REG_EVICT_MODE:    evict_mode <= cfg_data[0];
          default:           ;
        endcase
      end
      rd_vld <= issue;
      if (state == ST_IDLE && in_valid) begin
        iss <= '0;
        found <= 1'b0;
      end else if (issue) begin
        iss <= iss + NUM_W'(1);
      end
      if (rd_vld && !found && valid[cmp_idx] && ram_q.page == page) begin
        found <= 1'b1;
      end
      if (finish) begin
        valid[wr_idx] <= 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      page <= page_number;
      act <= act_now;
    end
    cmp_idx <= iss[IDX_W-1:0];
    if (rd_vld) begin
      if (!found && valid[cmp_idx] && ram_q.page == page) begin
        hit_idx <= cmp_idx;
        hit_cnt <= ram_q.count;
      end
      if (cmp_idx == '0 || better) begin
        vic_idx <= cmp_idx;
        vic_cnt <= ram_q.count;
        vic_page <= ram_q.page;
      end
    end
    if (finish) begin
      hit <= found;
      slot <= SLOT_W'(wr_idx);
      evicted <= !found && !free_found;
      evicted_page <= (!found && !free_found) ? vic_page : '0;
    end
  end

endmodule

// ===== tb/sv/fpr_checker.sv =====
`timescale 1ns / 100ps

module fpr_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [15:0]               page_number,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      hit,
  input  logic [3:0]                slot,
  input  logic                      evicted,
  input  logic [15:0]               evicted_page,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [fpr_pkg::CFG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        outstanding,
  output int                        checked_count,
  output int                        hit_count
);

  import fpr_pkg::*;

  typedef struct {
    logic        hit;
    logic [3:0]  slot;
    logic        evicted;
    page_t       evicted_page;
  } outcome_t;

  outcome_t          outcome_q[$];
  page_t             resident_page[FRAMES];
  logic              resident[FRAMES];
  count_t            use_cnt[FRAMES];
  logic [CFG_W-1:0]  frames_cfg;
  logic              mode_cfg;
  int                errors;
  int                checked;
  int                hits;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40) begin
      $display("mismatch: %s at result %0d, got %0h, want %0h", what, checked, got, want);
    end
  endtask

  task automatic reference_page(input page_t pg, output outcome_t o);
    int  n;
    int  pick;
    bit  found;
    n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
    found = 0;
    pick = 0;
    o.hit = 1'b0;
    o.evicted = 1'b0;
    o.evicted_page = '0;
    for (int i = 0; i < n; i++) begin
      if (!found && resident[i] && resident_page[i] == pg) begin
        found = 1;
        pick = i;
      end
    end
    if (found) begin
      o.hit = 1'b1;
      if (use_cnt[pick] != '1) use_cnt[pick] = use_cnt[pick] + 1'b1;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!found && !resident[i]) begin
          found = 1;
          pick = i;
        end
      end
      if (!found) begin
        pick = 0;
        for (int i = 1; i < n; i++) begin
          if ((mode_cfg == MODE_MFU) ? (use_cnt[i] > use_cnt[pick])
                                     : (use_cnt[i] < use_cnt[pick])) begin
            pick = i;
          end
        end
        o.evicted = 1'b1;
        o.evicted_page = resident_page[pick];
      end
      resident_page[pick] = pg;
      resident[pick] = 1'b1;
      use_cnt[pick] = count_t'(1);
    end
    o.slot = pick[3:0];
  endtask

  always @(posedge clk) begin
    outcome_t got_exp;
    outcome_t fresh;
    if (rst) begin
      frames_cfg = CFG_W'(FRAMES);
      mode_cfg = MODE_MFU;
      for (int i = 0; i < FRAMES; i++) resident[i] = 1'b0;
      outcome_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_FRAMES_IN_USE) frames_cfg = cfg_data;
        else mode_cfg = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected beat", slot, 0);
        end else begin
          got_exp = outcome_q.pop_front();
          if (hit !== got_exp.hit) report_mismatch("hit", hit, got_exp.hit);
          if (slot !== got_exp.slot) report_mismatch("slot", slot, got_exp.slot);
          if (evicted !== got_exp.evicted) report_mismatch("evicted", evicted, got_exp.evicted);
          if (evicted_page !== got_exp.evicted_page) begin
            report_mismatch("evicted_page", evicted_page, got_exp.evicted_page);
          end
          if (got_exp.hit) hits++;
        end
        checked++;
      end
      if (in_valid && in_ready) begin
        reference_page(page_number, fresh);
        outcome_q.insert(outcome_q.size(), fresh);
      end
    end
    fail_count <= errors;
    outstanding <= outcome_q.size();
    checked_count <= checked;
    hit_count <= hits;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import fpr_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 24;
  localparam int RANDOM_REFS = 500;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [15:0]       page_number = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              hit;
  logic [3:0]        slot;
  logic              evicted;
  logic [15:0]       evicted_page;
  logic              cfg_write = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_data = '0;

  int fail_count;
  int outstanding;
  int checked_count;
  int hit_count;

  int cycle_count = 0;
  int burst_left = 0;
  int tx_style = 1;
  int rx_style = 1;
  int rx_hold = 0;
  int sent_refs = 0;
  int reg_writes = 0;

  frequency_page_replacement_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .page_number  (page_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .slot         (slot),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  fpr_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .slot          (slot),
    .evicted       (evicted),
    .evicted_page  (evicted_page),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .hit_count     (hit_count)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_hold = $urandom_range(0, 7);
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end else begin
      rx_hold = rx_hold - 1;
    end
  end

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 24);
    if (tx_style == 0) return 0;
    if (tx_style == 1) return $urandom_range(1, 6);
    return $urandom_range(1, 30);
  endfunction

  task automatic send_page(input page_t pg);
    int gap;
    gap = next_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    page_number <= pg;
    do @(posedge clk); while (!in_ready);
    sent_refs++;
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_mode(input logic m);
    logic [CFG_W-1:0] d;
    d = CFG_W'($urandom_range(0, 31));
    d[0] = m;
    write_reg(REG_EVICT_MODE, d);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int               phase_refs;
    int               act;
    int               pool_n;
    logic [CFG_W-1:0] fr;
    page_t            pool[$];
    page_t            pg;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, fills, hits, clamped frame counts, both modes
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h5555);
    send_page(16'hAAAA);
    drain();
    write_reg(REG_FRAMES_IN_USE, 5'd0);
    send_page(16'hFFFF);
    send_page(16'h1234);
    send_page(16'h1234);
    drain();
    write_reg(REG_FRAMES_IN_USE, 5'd3);
    write_reg(REG_EVICT_MODE, 5'h1F);
    send_page(16'h5555);
    send_page(16'hFFFF);
    send_page(16'h7777);
    send_page(16'h1234);
    send_page(16'h7777);
    drain();
    write_reg(REG_FRAMES_IN_USE, 5'd31);
    write_reg(REG_EVICT_MODE, 5'h1E);
    send_page(16'h0001);
    send_page(16'h8000);
    send_page(16'h0001);
    send_page(16'h00FF);
    drain();
    write_reg(REG_FRAMES_IN_USE, 5'd17);
    send_page(16'hFF00);
    send_page(16'h8000);
    drain();
    write_reg(REG_FRAMES_IN_USE, 5'd16);
    send_page(16'h3C3C);
    send_page(16'hC3C3);
    drain();

    // random phases: small page pools so frames fill, hit and get evicted
    while (sent_refs < RANDOM_REFS + 21) begin
      case ($urandom_range(0, 7))
        0: fr = 5'd0;
        1: fr = 5'd1;
        2: fr = 5'd2;
        3: fr = 5'd16;
        4: fr = 5'd17;
        5: fr = 5'd31;
        6: fr = CFG_W'($urandom_range(1, 16));
        default: fr = CFG_W'($urandom_range(3, 8));
      endcase
      write_reg(REG_FRAMES_IN_USE, fr);
      set_mode(1'($urandom_range(0, 1)));
      act = (fr == 0) ? 1 : ((fr > FRAMES) ? FRAMES : int'(fr));
      pool_n = $urandom_range(1, act + 5);
      pool.delete();
      for (int i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 9))
          0: pool.insert(pool.size(), 16'h0000);
          1: pool.insert(pool.size(), 16'hFFFF);
          default: pool.insert(pool.size(), page_t'($urandom_range(0, 65535)));
        endcase
      end
      tx_style = $urandom_range(0, 2);
      rx_style = $urandom_range(0, 2);
      phase_refs = $urandom_range(30, 70);
      for (int k = 0; k < phase_refs; k++) begin
        if ($urandom_range(0, 9) == 0) pg = page_t'($urandom_range(0, 65535));
        else pg = pool[$urandom_range(0, pool_n - 1)];
        send_page(pg);
      end
      drain();
    end

    $display("covered %0d references (%0d hits) over %0d register writes",
             sent_refs, hit_count, reg_writes);
    $display("checked %0d result beats, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
